>>> rtl/dpni_pkg.sv
// shared constants and types for the depth pixel noise injector
package dpni_pkg;

  localparam int VAR_W  = 52;
  localparam int ROOT_W = VAR_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  localparam logic [12:0] MAX_SIDE = 13'd4096;

  // variance polynomial coefficients, q16 scaled magnitudes
  localparam logic [17:0] K00 = 18'd153616;
  localparam logic [23:0] K10 = 24'd12906376;
  localparam logic [20:0] K01 = 21'd1861868;
  localparam logic [24:0] K20 = 25'd19989121;
  localparam logic [22:0] K11 = 23'd7164418;
  localparam logic [20:0] K02 = 21'd1355698;

  localparam logic signed [19:0] DEPTH_MAX = 20'sh7ffff;
  localparam logic signed [19:0] DEPTH_MIN = 20'sh80000;

  localparam logic [1:0] CFG_NOISE_ENABLED = 2'd0;
  localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd1;
  localparam logic [1:0] CFG_IMAGE_HEIGHT  = 2'd2;

  typedef struct packed {
    logic signed [19:0] depth;
    logic [15:0]        smag;
    logic               sneg;
    logic               en;
  } dpni_pay_t;

endpackage

>>> rtl/dpni_sqrt_pipe.sv
// pipelined restoring integer square root, one result bit per stage
module dpni_sqrt_pipe (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_v,
  input  logic [dpni_pkg::VAR_W-1:0]  in_var,
  input  dpni_pkg::dpni_pay_t         in_pay,
  output logic                        out_v,
  output logic [dpni_pkg::ROOT_W-1:0] out_root,
  output dpni_pkg::dpni_pay_t         out_pay
);
  import dpni_pkg::*;

  logic              v_r    [ROOT_W];
  logic [VAR_W-1:0]  var_r  [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  dpni_pay_t         pay_r  [ROOT_W];

  genvar k;
  for (k = 0; k < ROOT_W; k++) begin : g_stage
    logic              src_v;
    logic [VAR_W-1:0]  src_var;
    logic [REM_W-1:0]  src_rem;
    logic [ROOT_W-1:0] src_root;
    dpni_pay_t         src_pay;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (k == 0) begin : g_first
      assign src_v    = in_v;
      assign src_var  = in_var;
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_pay  = in_pay;
    end else begin : g_next
      assign src_v    = v_r[k-1];
      assign src_var  = var_r[k-1];
      assign src_rem  = rem_r[k-1];
      assign src_root = root_r[k-1];
      assign src_pay  = pay_r[k-1];
    end

    assign rem_sh   = {src_rem[REM_W-3:0], src_var[VAR_W-1-2*k -: 2]};
    assign trial    = {src_root, 2'b01};
    assign ge       = (rem_sh >= trial);
    assign rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    assign root_nxt = {src_root[ROOT_W-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        var_r[k]  <= src_var;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        pay_r[k]  <= src_pay;
      end
    end
  end

  assign out_v    = v_r[ROOT_W-1];
  assign out_root = root_r[ROOT_W-1];
  assign out_pay  = pay_r[ROOT_W-1];

endmodule

>>> rtl/depth_pixel_noise_injector_unit.sv
// top level of the depth pixel noise injector
// Takes one pixel transaction per clock while in_stall is low and returns one result per pixel
// in order. A result passes through the 8-stage variance polynomial pipeline, the 26-stage
// square root (one root bit per stage) and two stages that scale and round the noise before
// the output register. A skid register behind the output holds one result while the consumer
// stalls; in_stall is high while it is occupied, and the whole pipeline then holds.
// Configuration writes are accepted in any cycle (cfg_ready is tied high) and must only be
// issued while no pixel is in flight.
module depth_pixel_noise_injector_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        in_pixel_column,
  input  logic [11:0]        in_pixel_row,
  input  logic signed [19:0] in_depth_value,
  input  logic signed [15:0] in_normal_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [19:0] out_noisy_depth,
  output logic               out_saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_wdata
);
  import dpni_pkg::*;

  // configuration registers
  logic        noise_enabled_r;
  logic [12:0] image_width_r;
  logic [12:0] image_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_enabled_r <= 1'b1;
      image_width_r   <= 13'd640;
      image_height_r  <= 13'd480;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NOISE_ENABLED: noise_enabled_r <= cfg_wdata[0];
        CFG_IMAGE_WIDTH:   image_width_r   <= cfg_wdata;
        CFG_IMAGE_HEIGHT:  image_height_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic sk_v_r;
  logic adv;

  assign adv      = !sk_v_r;
  assign in_stall = sk_v_r;

  // stage a: center offsets, magnitudes
  logic [12:0]        w_cl;
  logic [12:0]        h_cl;
  logic signed [13:0] dx_nxt;
  logic signed [13:0] dy_nxt;
  logic [19:0]        dm_nxt;
  dpni_pay_t          pay_nxt;

  assign w_cl   = (image_width_r > MAX_SIDE) ? MAX_SIDE : image_width_r;
  assign h_cl   = (image_height_r > MAX_SIDE) ? MAX_SIDE : image_height_r;
  assign dx_nxt = $signed({1'b0, in_pixel_column, 1'b0}) - $signed({1'b0, w_cl});
  assign dy_nxt = $signed({1'b0, in_pixel_row, 1'b0}) - $signed({1'b0, h_cl});
  assign dm_nxt = in_depth_value[19] ? ($unsigned(~in_depth_value) + 20'd1)
                                     : $unsigned(in_depth_value);

  always_comb begin
    pay_nxt.depth = in_depth_value;
    pay_nxt.smag  = in_normal_sample[15] ? ($unsigned(~in_normal_sample) + 16'd1)
                                         : $unsigned(in_normal_sample);
    pay_nxt.sneg  = in_normal_sample[15];
    pay_nxt.en    = noise_enabled_r;
  end

  logic               a_v_r;
  logic signed [13:0] a_dx_r;
  logic signed [13:0] a_dy_r;
  logic [19:0]        a_dm_r;
  dpni_pay_t          a_pay_r;

  // stage b: squares and the linear depth term
  logic signed [27:0] sqx_full;
  logic signed [27:0] sqy_full;
  logic [39:0]        dd_full;
  logic [40:0]        t01_full;

  assign sqx_full = a_dx_r * a_dx_r;
  assign sqy_full = a_dy_r * a_dy_r;
  assign dd_full  = a_dm_r * a_dm_r;
  assign t01_full = K01 * a_dm_r;

  logic        b_v_r;
  logic [25:0] b_sqx_r;
  logic [25:0] b_sqy_r;
  logic [38:0] b_dd_r;
  logic [19:0] b_t01_r;
  logic [19:0] b_dm_r;
  dpni_pay_t   b_pay_r;

  // stage c: radius and depth squared partial products
  logic [26:0] r4_nxt;
  logic [40:0] p02lo_nxt;
  logic [39:0] p02hi_nxt;

  assign r4_nxt    = {1'b0, b_sqx_r} + {1'b0, b_sqy_r};
  assign p02lo_nxt = K02 * b_dd_r[19:0];
  assign p02hi_nxt = K02 * b_dd_r[38:20];

  logic        c_v_r;
  logic [26:0] c_r4_r;
  logic [40:0] c_p02lo_r;
  logic [39:0] c_p02hi_r;
  logic [19:0] c_t01_r;
  logic [19:0] c_dm_r;
  dpni_pay_t   c_pay_r;

  // stage d: radius products and linear radius term
  logic [53:0] rr_full;
  logic [46:0] rd_full;
  logic [50:0] t10_full;
  logic [59:0] p02_sum;

  assign rr_full  = c_r4_r * c_r4_r;
  assign rd_full  = c_r4_r * c_dm_r;
  assign t10_full = K10 * c_r4_r;
  assign p02_sum  = {c_p02hi_r, 20'd0} + 60'(c_p02lo_r);

  logic        d_v_r;
  logic [53:0] d_rr_r;
  logic [46:0] d_rd_r;
  logic [34:0] d_t10_r;
  logic [22:0] d_t02_r;
  logic [19:0] d_t01_r;
  dpni_pay_t   d_pay_r;

  // stage e: quadratic partial products, negative sum
  logic [44:0] p20lo_nxt;
  logic [42:0] p20hi_nxt;
  logic [42:0] p11lo_nxt;
  logic [41:0] p11hi_nxt;
  logic [35:0] neg_nxt;

  assign p20lo_nxt = K20 * d_rr_r[35:16];
  assign p20hi_nxt = K20 * d_rr_r[53:36];
  assign p11lo_nxt = K11 * d_rd_r[27:8];
  assign p11hi_nxt = K11 * d_rd_r[46:28];
  assign neg_nxt   = 36'(d_t10_r) + 36'(d_t01_r);

  logic        e_v_r;
  logic [44:0] e_p20lo_r;
  logic [42:0] e_p20hi_r;
  logic [42:0] e_p11lo_r;
  logic [41:0] e_p11hi_r;
  logic [35:0] e_neg_r;
  logic [22:0] e_t02_r;
  dpni_pay_t   e_pay_r;

  // stage f: combine partial products
  logic [62:0] p20_sum;
  logic [61:0] p11_sum;

  assign p20_sum = {e_p20hi_r, 20'd0} + 63'(e_p20lo_r);
  assign p11_sum = {e_p11hi_r, 20'd0} + 62'(e_p11lo_r);

  logic        f_v_r;
  logic [50:0] f_t20_r;
  logic [36:0] f_t11_r;
  logic [35:0] f_neg_r;
  logic [22:0] f_t02_r;
  dpni_pay_t   f_pay_r;

  // stage g: positive sum
  logic [51:0] pos_nxt;

  assign pos_nxt = 52'(K00) + 52'(f_t20_r) + 52'(f_t11_r) + 52'(f_t02_r);

  logic        g_v_r;
  logic [51:0] g_pos_r;
  logic [35:0] g_neg_r;
  dpni_pay_t   g_pay_r;

  // stage h: variance clamped at zero
  logic [51:0] var_nxt;

  assign var_nxt = (g_pos_r > 52'(g_neg_r)) ? (g_pos_r - 52'(g_neg_r)) : '0;

  logic        h_v_r;
  logic [51:0] h_var_r;
  dpni_pay_t   h_pay_r;

  logic              s_v;
  logic [ROOT_W-1:0] s_root;
  dpni_pay_t         s_pay;

  dpni_sqrt_pipe u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (h_v_r),
    .in_var   (h_var_r),
    .in_pay   (h_pay_r),
    .out_v    (s_v),
    .out_root (s_root),
    .out_pay  (s_pay)
  );

  // stage m: noise magnitude
  logic [41:0] mag_nxt;

  assign mag_nxt = s_pay.smag * s_root;

  logic        m_v_r;
  logic [41:0] m_mag_r;
  dpni_pay_t   m_pay_r;

  // stage n: round to 1/64 mm
  logic [41:0] rnd_sum;

  assign rnd_sum = m_mag_r + 42'd8192;

  logic        n_v_r;
  logic [27:0] n_noise_r;
  dpni_pay_t   n_pay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
      g_v_r <= 1'b0;
      h_v_r <= 1'b0;
      m_v_r <= 1'b0;
      n_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
      e_v_r <= d_v_r;
      f_v_r <= e_v_r;
      g_v_r <= f_v_r;
      h_v_r <= g_v_r;
      m_v_r <= s_v;
      n_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_dx_r    <= dx_nxt;
      a_dy_r    <= dy_nxt;
      a_dm_r    <= dm_nxt;
      a_pay_r   <= pay_nxt;

      b_sqx_r   <= sqx_full[25:0];
      b_sqy_r   <= sqy_full[25:0];
      b_dd_r    <= dd_full[38:0];
      b_t01_r   <= t01_full[39:20];
      b_dm_r    <= a_dm_r;
      b_pay_r   <= a_pay_r;

      c_r4_r    <= r4_nxt;
      c_p02lo_r <= p02lo_nxt;
      c_p02hi_r <= p02hi_nxt;
      c_t01_r   <= b_t01_r;
      c_dm_r    <= b_dm_r;
      c_pay_r   <= b_pay_r;

      d_rr_r    <= rr_full;
      d_rd_r    <= rd_full;
      d_t10_r   <= t10_full[50:16];
      d_t02_r   <= p02_sum[58:36];
      d_t01_r   <= c_t01_r;
      d_pay_r   <= c_pay_r;

      e_p20lo_r <= p20lo_nxt;
      e_p20hi_r <= p20hi_nxt;
      e_p11lo_r <= p11lo_nxt;
      e_p11hi_r <= p11hi_nxt;
      e_neg_r   <= neg_nxt;
      e_t02_r   <= d_t02_r;
      e_pay_r   <= d_pay_r;

      f_t20_r   <= p20_sum[62:12];
      f_t11_r   <= p11_sum[60:24];
      f_neg_r   <= e_neg_r;
      f_t02_r   <= e_t02_r;
      f_pay_r   <= e_pay_r;

      g_pos_r   <= pos_nxt;
      g_neg_r   <= f_neg_r;
      g_pay_r   <= f_pay_r;

      h_var_r   <= var_nxt;
      h_pay_r   <= g_pay_r;

      m_mag_r   <= mag_nxt;
      m_pay_r   <= s_pay;

      n_noise_r <= rnd_sum[41:14];
      n_pay_r   <= m_pay_r;
    end
  end

  // final add and saturation
  logic signed [29:0] dep_ext;
  logic signed [29:0] noise_ext;
  logic signed [29:0] sum_full;
  logic               ovf;
  logic signed [19:0] res_depth_nxt;
  logic               res_sat_nxt;

  assign dep_ext   = 30'(n_pay_r.depth);
  assign noise_ext = $signed({2'b00, n_noise_r});
  assign sum_full  = n_pay_r.sneg ? (dep_ext - noise_ext) : (dep_ext + noise_ext);
  assign ovf       = !((&sum_full[29:19]) || !(|sum_full[29:19]));

  always_comb begin
    priority if (!n_pay_r.en) begin
      res_depth_nxt = n_pay_r.depth;
    end else if (ovf) begin
      res_depth_nxt = sum_full[29] ? DEPTH_MIN : DEPTH_MAX;
    end else begin
      res_depth_nxt = $signed(sum_full[19:0]);
    end
  end

  assign res_sat_nxt = n_pay_r.en && ovf;

  // output register and skid register
  logic               o_v_r;
  logic signed [19:0] o_depth_r;
  logic               o_sat_r;
  logic signed [19:0] sk_depth_r;
  logic               sk_sat_r;
  logic               out_take;

  assign out_take = o_v_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r  <= 1'b0;
      sk_v_r <= 1'b0;
    end else begin
      priority if (sk_v_r) begin
        if (out_take) begin
          sk_v_r <= 1'b0;
        end
      end else if (!o_v_r || out_take) begin
        o_v_r <= n_v_r;
      end else if (n_v_r) begin
        sk_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (sk_v_r) begin
      if (out_take) begin
        o_depth_r <= sk_depth_r;
        o_sat_r   <= sk_sat_r;
      end
    end else if (!o_v_r || out_take) begin
      o_depth_r <= res_depth_nxt;
      o_sat_r   <= res_sat_nxt;
    end else begin
      sk_depth_r <= res_depth_nxt;
      sk_sat_r   <= res_sat_nxt;
    end
  end

  assign out_valid       = o_v_r;
  assign out_noisy_depth = o_depth_r;
  assign out_saturated   = o_sat_r;

  assert property (@(posedge clk) disable iff (!rst_n) sk_v_r |-> o_v_r)
    else $error("skid register full while output register empty");

  assert property (@(posedge clk) disable iff (!rst_n) sk_v_r && !out_stall |=> !sk_v_r)
    else $error("skid register not drained after output transaction");

  assert property (@(posedge clk) disable iff (!rst_n)
      !sk_v_r && o_v_r && out_stall && n_v_r |=> sk_v_r)
    else $error("result lost while output stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
      o_v_r && o_sat_r |-> (o_depth_r == DEPTH_MAX || o_depth_r == DEPTH_MIN))
    else $error("saturated flag set on unclamped depth");

endmodule
